// ===== rtl/core/slt_pkg.sv =====
// Shared constants, result/bundle types and a result builder for the shell line tokenizer.
// Used by slt_front, slt_queue, slt_back and shell_line_tokenizer_top; no dependencies.
package slt_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int TOKEN_SLOTS = 64;
   localparam int MAX_RES     = 4;
   localparam int RES_IDX_W   = $clog2(MAX_RES);
   localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   localparam logic [3:0] TOK_WORD   = 4'd0;
   localparam logic [3:0] TOK_IN     = 4'd1;
   localparam logic [3:0] TOK_OUT    = 4'd2;
   localparam logic [3:0] TOK_APPEND = 4'd3;
   localparam logic [3:0] TOK_PIPE   = 4'd4;
   localparam logic [3:0] TOK_OR     = 4'd5;
   localparam logic [3:0] TOK_AND    = 4'd6;
   localparam logic [3:0] TOK_SEMI   = 4'd7;
   localparam logic [3:0] TOK_END    = 4'd8;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_GT   = 2'd1;
   localparam logic [1:0] OP_BAR  = 2'd2;
   localparam logic [1:0] OP_AMP  = 2'd3;

   localparam logic CSR_MAX_TOKENS = 1'b0;
   localparam logic CSR_TEXT_CAP   = 1'b1;

   typedef struct packed {
      logic       store_we;
      logic [9:0] store_addr;
      logic [7:0] store_byte;
      logic       tok_we;
      logic [5:0] tok_index;
      logic [3:0] tok_type;
      logic [9:0] tok_text;
      logic       done_res;
      logic       error;
      logic [5:0] token_total;
      logic       last;
   } rsp_type;

   typedef struct packed {
      rsp_type [MAX_RES-1:0] res;
      logic [RES_CNT_W-1:0]  cnt;
   } bundle_type;

   function automatic rsp_type mk_res(input logic swe, input logic [9:0] addr,
                                      input logic [7:0] sbyte, input logic twe,
                                      input logic [5:0] idx, input logic [3:0] ttype,
                                      input logic [9:0] text, input logic done,
                                      input logic err, input logic [5:0] total);
      rsp_type r;
      r.store_we    = swe;
      r.store_addr  = addr;
      r.store_byte  = sbyte;
      r.tok_we      = twe;
      r.tok_index   = idx;
      r.tok_type    = ttype;
      r.tok_text    = text;
      r.done_res    = done;
      r.error       = err;
      r.token_total = total;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

// ===== rtl/core/slt_front.sv =====
// Front end: configuration registers, lexer line state and the per-byte result bundle.
// Depends on slt_pkg.
module slt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         ch,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [10:0]        csr_wdata,
   output slt_pkg::bundle_type bundle,
   output logic               bundle_push
);

   logic [6:0]  max_tokens_ff;
   logic [10:0] text_cap_ff;

   logic [9:0]  write_offset_ff, write_offset_in;
   logic [5:0]  token_count_ff, token_count_in;
   logic [9:0]  word_begin_ff, word_begin_in;
   logic        inside_word_ff, inside_word_in;
   logic        inside_single_ff, inside_single_in;
   logic        inside_double_ff, inside_double_in;
   logic        escape_pending_ff, escape_pending_in;
   logic [1:0]  operator_pending_ff, operator_pending_in;
   logic        comment_skip_ff, comment_skip_in;
   logic        line_failed_ff, line_failed_in;

   logic [10:0] slim;
   logic [6:0]  tlim;
   logic        ok;
   logic        consumed;
   logic [slt_pkg::RES_CNT_W-1:0] n;
   slt_pkg::rsp_type [slt_pkg::MAX_RES-1:0] r;
   logic [7:0]  pc;

   always_comb begin
      slim = (text_cap_ff < 11'(slt_pkg::STORE_DEPTH)) ? text_cap_ff
                                                       : 11'(slt_pkg::STORE_DEPTH);
      tlim = (max_tokens_ff < 7'(slt_pkg::TOKEN_SLOTS)) ? max_tokens_ff
                                                        : 7'(slt_pkg::TOKEN_SLOTS);

      write_offset_in     = write_offset_ff;
      token_count_in      = token_count_ff;
      word_begin_in       = word_begin_ff;
      inside_word_in      = inside_word_ff;
      inside_single_in    = inside_single_ff;
      inside_double_in    = inside_double_ff;
      escape_pending_in   = escape_pending_ff;
      operator_pending_in = operator_pending_ff;
      comment_skip_in     = comment_skip_ff;
      line_failed_in      = line_failed_ff;
      ok       = 1'b1;
      consumed = 1'b0;
      n        = '0;
      r        = '0;
      pc       = slt_pkg::CH_AMP;

      if (line_failed_ff) begin
         if (ch == slt_pkg::CH_NUL) begin
            line_failed_in = 1'b0;
            write_offset_in = '0; token_count_in = '0; word_begin_in = '0;
            inside_word_in = 1'b0; inside_single_in = 1'b0; inside_double_in = 1'b0;
            escape_pending_in = 1'b0; operator_pending_in = slt_pkg::OP_NONE;
            comment_skip_in = 1'b0;
         end
      end else if (!(comment_skip_ff && ch != slt_pkg::CH_NUL)) begin
         // pending escape or operator first
         if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
            if (({1'b0, write_offset_in} + 11'd1) >= slim) begin
               ok = 1'b0;
            end else begin
               r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b1, write_offset_in,
                  (ch != slt_pkg::CH_NUL) ? ch : slt_pkg::CH_BSLASH,
                  1'b0, '0, '0, '0, 1'b0, 1'b0, '0);
               n = n + 1'b1;
               write_offset_in = write_offset_in + 10'd1;
            end
            consumed = (ch != slt_pkg::CH_NUL);
         end else if (operator_pending_ff != slt_pkg::OP_NONE) begin
            operator_pending_in = slt_pkg::OP_NONE;
            case (operator_pending_ff)
               slt_pkg::OP_GT:  pc = slt_pkg::CH_GT;
               slt_pkg::OP_BAR: pc = slt_pkg::CH_BAR;
               default:         pc = slt_pkg::CH_AMP;
            endcase
            if (ch != pc && operator_pending_ff == slt_pkg::OP_AMP) begin
               ok = 1'b0;
            end else if (({1'b0, token_count_in} + 7'd1) >= tlim) begin
               ok = 1'b0;
               consumed = (ch == pc);
            end else begin
               r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b0, '0, '0, 1'b1,
                  token_count_in,
                  (ch == pc) ? ((operator_pending_ff == slt_pkg::OP_GT) ? slt_pkg::TOK_APPEND :
                                (operator_pending_ff == slt_pkg::OP_BAR) ? slt_pkg::TOK_OR :
                                slt_pkg::TOK_AND)
                             : ((operator_pending_ff == slt_pkg::OP_GT) ? slt_pkg::TOK_OUT :
                                slt_pkg::TOK_PIPE),
                  '0, 1'b0, 1'b0, '0);
               n = n + 1'b1;
               token_count_in = token_count_in + 6'd1;
               consumed = (ch == pc);
            end
         end

         if (ok && !consumed) begin
            if (ch == slt_pkg::CH_NUL) begin
               // close the line
               if (inside_single_in || inside_double_in) begin
                  ok = 1'b0;
               end else begin
                  if (inside_word_in) begin
                     if ((({1'b0, token_count_in} + 7'd1) >= tlim) ||
                         (({1'b0, write_offset_in} + 11'd1) >= slim)) begin
                        ok = 1'b0;
                     end else begin
                        r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b1, write_offset_in,
                           8'h00, 1'b1, token_count_in, slt_pkg::TOK_WORD, word_begin_in,
                           1'b0, 1'b0, '0);
                        n = n + 1'b1;
                        write_offset_in = write_offset_in + 10'd1;
                        token_count_in  = token_count_in + 6'd1;
                        inside_word_in  = 1'b0;
                     end
                  end
                  if (ok) begin
                     r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b0, '0, '0, 1'b1,
                        token_count_in, slt_pkg::TOK_END, '0, 1'b1, 1'b0, token_count_in);
                     n = n + 1'b1;
                     write_offset_in = '0; token_count_in = '0; word_begin_in = '0;
                     inside_word_in = 1'b0; inside_single_in = 1'b0;
                     inside_double_in = 1'b0; escape_pending_in = 1'b0;
                     operator_pending_in = slt_pkg::OP_NONE;
                     comment_skip_in = 1'b0; line_failed_in = 1'b0;
                  end
               end
            end else if (inside_single_in) begin
               if (ch == slt_pkg::CH_SQUOTE) begin
                  inside_single_in = 1'b0;
               end else if (({1'b0, write_offset_in} + 11'd1) >= slim) begin
                  ok = 1'b0;
               end else begin
                  r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b1, write_offset_in, ch,
                     1'b0, '0, '0, '0, 1'b0, 1'b0, '0);
                  n = n + 1'b1;
                  write_offset_in = write_offset_in + 10'd1;
               end
            end else if (inside_double_in) begin
               if (ch == slt_pkg::CH_DQUOTE) begin
                  inside_double_in = 1'b0;
               end else if (ch == slt_pkg::CH_BSLASH) begin
                  escape_pending_in = 1'b1;
               end else if (({1'b0, write_offset_in} + 11'd1) >= slim) begin
                  ok = 1'b0;
               end else begin
                  r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b1, write_offset_in, ch,
                     1'b0, '0, '0, '0, 1'b0, 1'b0, '0);
                  n = n + 1'b1;
                  write_offset_in = write_offset_in + 10'd1;
               end
            end else if (ch == slt_pkg::CH_SPACE || ch == slt_pkg::CH_TAB ||
                         ch == slt_pkg::CH_LT || ch == slt_pkg::CH_GT ||
                         ch == slt_pkg::CH_BAR || ch == slt_pkg::CH_AMP ||
                         ch == slt_pkg::CH_SEMI) begin
               // separators and operators close an open word
               if (inside_word_in) begin
                  if ((({1'b0, token_count_in} + 7'd1) >= tlim) ||
                      (({1'b0, write_offset_in} + 11'd1) >= slim)) begin
                     ok = 1'b0;
                  end else begin
                     r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b1, write_offset_in,
                        8'h00, 1'b1, token_count_in, slt_pkg::TOK_WORD, word_begin_in,
                        1'b0, 1'b0, '0);
                     n = n + 1'b1;
                     write_offset_in = write_offset_in + 10'd1;
                     token_count_in  = token_count_in + 6'd1;
                     inside_word_in  = 1'b0;
                  end
               end
               if (ok && (ch == slt_pkg::CH_LT || ch == slt_pkg::CH_SEMI)) begin
                  if (({1'b0, token_count_in} + 7'd1) >= tlim) begin
                     ok = 1'b0;
                  end else begin
                     r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b0, '0, '0, 1'b1,
                        token_count_in,
                        (ch == slt_pkg::CH_LT) ? slt_pkg::TOK_IN : slt_pkg::TOK_SEMI,
                        '0, 1'b0, 1'b0, '0);
                     n = n + 1'b1;
                     token_count_in = token_count_in + 6'd1;
                  end
               end else if (ok && ch == slt_pkg::CH_GT) begin
                  operator_pending_in = slt_pkg::OP_GT;
               end else if (ok && ch == slt_pkg::CH_BAR) begin
                  operator_pending_in = slt_pkg::OP_BAR;
               end else if (ok && ch == slt_pkg::CH_AMP) begin
                  operator_pending_in = slt_pkg::OP_AMP;
               end
            end else if (ch == slt_pkg::CH_HASH && !inside_word_in) begin
               comment_skip_in = 1'b1;
            end else begin
               // word character, quote or backslash: open the word if needed
               if (!inside_word_in) begin
                  inside_word_in = 1'b1;
                  word_begin_in  = write_offset_in;
               end
               if (ch == slt_pkg::CH_SQUOTE) begin
                  inside_single_in = 1'b1;
               end else if (ch == slt_pkg::CH_DQUOTE) begin
                  inside_double_in = 1'b1;
               end else if (ch == slt_pkg::CH_BSLASH) begin
                  escape_pending_in = 1'b1;
               end else if (({1'b0, write_offset_in} + 11'd1) >= slim) begin
                  ok = 1'b0;
               end else begin
                  r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b1, write_offset_in, ch,
                     1'b0, '0, '0, '0, 1'b0, 1'b0, '0);
                  n = n + 1'b1;
                  write_offset_in = write_offset_in + 10'd1;
               end
            end
         end

         if (!ok) begin
            r[n[slt_pkg::RES_IDX_W-1:0]] = slt_pkg::mk_res(1'b0, '0, '0, 1'b0, '0, '0, '0,
                                                            1'b1, 1'b1, '0);
            n = n + 1'b1;
            if (ch == slt_pkg::CH_NUL) begin
               write_offset_in = '0; token_count_in = '0; word_begin_in = '0;
               inside_word_in = 1'b0; inside_single_in = 1'b0; inside_double_in = 1'b0;
               escape_pending_in = 1'b0; operator_pending_in = slt_pkg::OP_NONE;
               comment_skip_in = 1'b0; line_failed_in = 1'b0;
            end else begin
               line_failed_in = 1'b1;
            end
         end
      end

      if (n != '0) begin
         r[slt_pkg::RES_IDX_W'(n - 1'b1)].last = 1'b1;
      end
   end

   assign bundle.res    = r;
   assign bundle.cnt    = n;
   assign bundle_push   = accept && (n != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tokens_ff <= 7'(slt_pkg::TOKEN_SLOTS);
         text_cap_ff   <= 11'(slt_pkg::STORE_DEPTH);
      end else if (csr_we) begin
         if (csr_index == slt_pkg::CSR_MAX_TOKENS) begin
            max_tokens_ff <= csr_wdata[6:0];
         end else begin
            text_cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_offset_ff     <= '0;
         token_count_ff      <= '0;
         word_begin_ff       <= '0;
         inside_word_ff      <= 1'b0;
         inside_single_ff    <= 1'b0;
         inside_double_ff    <= 1'b0;
         escape_pending_ff   <= 1'b0;
         operator_pending_ff <= slt_pkg::OP_NONE;
         comment_skip_ff     <= 1'b0;
         line_failed_ff      <= 1'b0;
      end else if (accept) begin
         write_offset_ff     <= write_offset_in;
         token_count_ff      <= token_count_in;
         word_begin_ff       <= word_begin_in;
         inside_word_ff      <= inside_word_in;
         inside_single_ff    <= inside_single_in;
         inside_double_ff    <= inside_double_in;
         escape_pending_ff   <= escape_pending_in;
         operator_pending_ff <= operator_pending_in;
         comment_skip_ff     <= comment_skip_in;
         line_failed_ff      <= line_failed_in;
      end
   end

endmodule

// ===== rtl/core/slt_queue.sv =====
// Short bundle queue between the front end and the result sequencer.
// Depends on slt_pkg.
module slt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  slt_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output slt_pkg::bundle_type head,
   output logic                head_valid
);

   slt_pkg::bundle_type entry_ff [slt_pkg::QUEUE_DEPTH];
   logic [slt_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [slt_pkg::QCNT_W-1:0] count_ff;

   assign full       = (count_ff == slt_pkg::QCNT_W'(slt_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/slt_back.sv =====
// Result sequencer: walks the head bundle one result per cycle into the output register
// while that register is empty or being taken. Depends on slt_pkg.
module slt_back (
   input  logic                clock,
   input  logic                reset,
   input  slt_pkg::bundle_type head,
   input  logic                head_valid,
   output logic                head_pop,
   input  logic                out_take,
   output logic                out_valid,
   output slt_pkg::rsp_type    out_res
);

   logic [slt_pkg::RES_IDX_W-1:0] ridx_ff;
   logic                          out_valid_ff;
   slt_pkg::rsp_type              out_ff;
   logic                          load;
   logic                          at_last;

   assign load      = head_valid && (!out_valid_ff || out_take);
   assign at_last   = ((slt_pkg::RES_CNT_W'(ridx_ff) + 1'b1) == head.cnt);
   assign head_pop  = load && at_last;
   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= head.res[ridx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ridx_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            ridx_ff <= at_last ? '0 : ridx_ff + 1'b1;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/shell_line_tokenizer_top.sv =====
// Shell command line tokenizer, top level: front end, bundle queue and result sequencer.
// Depends on slt_pkg, slt_front, slt_queue and slt_back.
//
// Usage:
//   Input side is a queue write port: drive req_ch and raise req_push; a beat is
//   taken at a rising edge with req_push high and req_full low. A 0 byte ends the line.
//   Result side is a queue read port: while rsp_empty is low the oldest result sits on
//   the rsp_ ports; raise rsp_pop to take it. rsp_last marks the final result of a byte.
//   Configuration: csr_we with csr_index (0 = max_tokens, 1 = text_cap) and csr_wdata
//   writes a register at the edge; write only while the block is idle.
// Timing:
//   A byte is classified in the cycle it is accepted; its results pass through the
//   bundle queue and then the output register before they reach the rsp_ ports. The
//   front end takes one byte per cycle while the two-entry bundle queue has room. The
//   output register delivers one result per cycle while rsp_pop is raised, so bytes
//   that give several results (up to three) are paced by the result side.
// Reset: synchronous, active high; clears line state, empties the queue and the output
//   register, and sets max_tokens to 64 and text_cap to 1024.
// Stall: when rsp_pop stays low the output holds, the queue fills and req_full rises;
//   no result is dropped and no byte is taken until room frees up.
module shell_line_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_ch,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_store_we,
   output logic [9:0]  rsp_store_addr,
   output logic [7:0]  rsp_store_byte,
   output logic        rsp_tok_we,
   output logic [5:0]  rsp_tok_index,
   output logic [3:0]  rsp_tok_type,
   output logic [9:0]  rsp_tok_text,
   output logic        rsp_done_res,
   output logic        rsp_error,
   output logic [5:0]  rsp_token_total,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);

   logic                accept;
   logic                bundle_push;
   slt_pkg::bundle_type bundle;
   slt_pkg::bundle_type head;
   logic                head_valid;
   logic                head_pop;
   logic                q_full;
   logic                out_valid;
   logic                out_take;
   slt_pkg::rsp_type    out_res;

   // take a byte whenever the queue has a free slot
   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign out_take = rsp_pop && out_valid;

   slt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .bundle      (bundle),
      .bundle_push (bundle_push)
   );

   slt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (bundle_push),
      .push_data  (bundle),
      .full       (q_full),
      .pop        (head_pop),
      .head       (head),
      .head_valid (head_valid)
   );

   slt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .out_take   (out_take),
      .out_valid  (out_valid),
      .out_res    (out_res)
   );

   // drive the result beat from the output register
   assign rsp_empty       = !out_valid;
   assign rsp_store_we    = out_res.store_we;
   assign rsp_store_addr  = out_res.store_addr;
   assign rsp_store_byte  = out_res.store_byte;
   assign rsp_tok_we      = out_res.tok_we;
   assign rsp_tok_index   = out_res.tok_index;
   assign rsp_tok_type    = out_res.tok_type;
   assign rsp_tok_text    = out_res.tok_text;
   assign rsp_done_res    = out_res.done_res;
   assign rsp_error       = out_res.error;
   assign rsp_token_total = out_res.token_total;
   assign rsp_last        = out_res.last;

   // a finished line is always the final result of its byte
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |-> rsp_last)
      else $error("done result not marked last");

   // a failure result carries no store or token write
   a_error_plain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> (rsp_done_res && !rsp_store_we && !rsp_tok_we))
      else $error("error result carries a write or lacks done");

   // the queue never drains a bundle that is not there
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("bundle queue popped while empty");

   // reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result side not empty after reset");

endmodule
